### rtl/ptt_pkg.sv
// Package for the periodic task timer table.
// Holds slot count, field widths, action codes and the table word layout.
// No dependencies.
package ptt_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W       = SLOT_W + 1;

  localparam int ACTION_W    = 3;
  localparam int SLOT_FLD_W  = 4;
  localparam int PERIOD_W    = 16;
  localparam int TIME_W      = 32;
  localparam int MASK_W      = 16;
  localparam int MASK_PAD_W  = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;
  localparam int WORD_W      = 2 * PERIOD_W;

  localparam logic [ACTION_W-1:0] ACT_TICK     = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLAIM    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_SET_TIME = 3'd4;

  // One table entry: reload period in the upper half, countdown in the lower.
  typedef struct packed {
    logic [PERIOD_W-1:0] reload;
    logic [PERIOD_W-1:0] countdown;
  } slot_word_t;

endpackage

### rtl/ptt_in_if.sv
// Input channel of the periodic task timer table: valid/ready plus one action.
// Depends on ptt_pkg.
interface ptt_in_if;
  logic                           valid;
  logic                           ready;
  logic [ptt_pkg::ACTION_W-1:0]   action;
  logic [ptt_pkg::SLOT_FLD_W-1:0] slot;
  logic [ptt_pkg::PERIOD_W-1:0]   period;
  logic [ptt_pkg::PERIOD_W-1:0]   first_expire;
  logic [ptt_pkg::TIME_W-1:0]     time_value;

  modport source (output valid, action, slot, period, first_expire, time_value,
                  input ready);
  modport sink   (input valid, action, slot, period, first_expire, time_value,
                  output ready);
endinterface

### rtl/ptt_out_if.sv
// Result channel of the periodic task timer table: valid/ready plus one result.
// Depends on ptt_pkg.
interface ptt_out_if;
  logic                           valid;
  logic                           ready;
  logic [ptt_pkg::MASK_W-1:0]     ready_mask;
  logic [ptt_pkg::TIME_W-1:0]     time_now;
  logic [ptt_pkg::SLOT_FLD_W-1:0] claimed_slot;
  logic                           claim_found;

  modport source (output valid, ready_mask, time_now, claimed_slot, claim_found,
                  input ready);
  modport sink   (input valid, ready_mask, time_now, claimed_slot, claim_found,
                  output ready);
endinterface

### rtl/ptt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/periodic_task_timer_table_top.sv
// Periodic task timer table: sequencer, slot flag registers and table RAM.
// Depends on ptt_pkg, ptt_in_if, ptt_out_if and ptt_ram.
//
// Usage:
//   in_ch carries one action per transfer (tick, add, remove, claim, set time)
//   with its slot, period, first expiry and time value. out_ch returns exactly
//   one result per action: the ready mask, the tick count, and for a claim the
//   slot handed out and a found flag.
// Sequencing:
//   after the in_ch transfer, add, remove, set time and unused codes go
//   straight to the output state; a claim first scans the ready flags (one
//   ready flag scanned per cycle) and a tick first walks every slot through
//   the countdown RAM's one read and one write port. The output state loads
//   the result and returns to idle; in_ch.ready is high only when idle.
// Reset:
//   rst (synchronous) empties every slot, clears all ready flags, sets the
//   tick count to zero and drops out_ch.valid. No clearing pass is needed.
// Stall:
//   a held result stays in the output register; the next action is taken
//   meanwhile and its result waits until the pending one is transferred.
module periodic_task_timer_table_top (
  input  logic         clk,
  input  logic         rst,
  ptt_in_if.sink       in_ch,
  ptt_out_if.source    out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_CLAIM,
    S_OUT
  } state_t;

  localparam logic [ptt_pkg::CNT_W-1:0] LAST_CNT = ptt_pkg::CNT_W'(ptt_pkg::NUM_SLOTS);

  state_t                          state;
  logic [ptt_pkg::NUM_SLOTS-1:0]   slot_in_use;
  logic [ptt_pkg::NUM_SLOTS-1:0]   slot_ready;
  logic [ptt_pkg::NUM_SLOTS-1:0]   slot_oneshot;
  logic [ptt_pkg::TIME_W-1:0]      tick_count;

  logic [ptt_pkg::CNT_W-1:0]       walk;
  logic                            pend_v;
  logic [ptt_pkg::SLOT_W-1:0]      pend_idx;
  logic [ptt_pkg::SLOT_FLD_W-1:0]  res_claimed;
  logic                            res_found;

  logic                            in_xfer;
  logic                            slot_ok;
  logic [ptt_pkg::SLOT_W-1:0]      in_idx;
  logic [ptt_pkg::SLOT_W-1:0]      walk_idx;
  logic                            out_free;

  logic                            ram_we;
  logic [ptt_pkg::SLOT_W-1:0]      ram_waddr;
  ptt_pkg::slot_word_t             ram_wdata;
  ptt_pkg::slot_word_t             ram_rdata;

  logic [ptt_pkg::PERIOD_W-1:0]    cd_dec;
  logic                            cd_expire;
  logic [ptt_pkg::MASK_PAD_W-1:0]  mask_pad;

  assign in_ch.ready = (state == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign slot_ok     = (int'(in_ch.slot) < ptt_pkg::NUM_SLOTS);
  assign in_idx      = ptt_pkg::SLOT_W'(in_ch.slot);
  assign walk_idx    = walk[ptt_pkg::SLOT_W-1:0];
  assign out_free    = !out_ch.valid || out_ch.ready;

  // Shared countdown unit: decrement and detect expiry.
  assign cd_dec    = ram_rdata.countdown - 1'b1;
  assign cd_expire = (cd_dec == '0);

  assign mask_pad  = ptt_pkg::MASK_PAD_W'(slot_ready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_idx;
    ram_wdata = '{reload: in_ch.period, countdown: in_ch.first_expire};
    if (state == S_TICK) begin
      ram_we    = pend_v && slot_in_use[pend_idx];
      ram_waddr = pend_idx;
      ram_wdata = '{reload:    ram_rdata.reload,
                    countdown: cd_expire ? ram_rdata.reload : cd_dec};
    end else if (in_xfer && in_ch.action == ptt_pkg::ACT_ADD && slot_ok) begin
      ram_we = 1'b1;
    end
  end

  ptt_ram #(
    .WIDTH (ptt_pkg::WORD_W),
    .DEPTH (ptt_pkg::NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (walk_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_in_use   <= '0;
      slot_ready    <= '0;
      tick_count    <= '0;
      pend_v        <= 1'b0;
      out_ch.valid  <= 1'b0;
    end else begin
      // Drop valid after the transfer unless a new result is loaded now.
      if (out_ch.valid && out_ch.ready && state != S_OUT) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            res_claimed <= '0;
            res_found   <= 1'b0;
            walk        <= '0;
            pend_v      <= 1'b0;
            unique case (in_ch.action)
              ptt_pkg::ACT_TICK: begin
                tick_count <= tick_count + 1'b1;
                state      <= S_TICK;
              end
              ptt_pkg::ACT_ADD: begin
                if (slot_ok) begin
                  slot_in_use[in_idx]  <= 1'b1;
                  slot_ready[in_idx]   <= (in_ch.period == '0);
                  slot_oneshot[in_idx] <= (in_ch.period == '0);
                end
                state <= S_OUT;
              end
              ptt_pkg::ACT_REMOVE: begin
                if (slot_ok) begin
                  slot_in_use[in_idx] <= 1'b0;
                  slot_ready[in_idx]  <= 1'b0;
                end
                state <= S_OUT;
              end
              ptt_pkg::ACT_CLAIM: begin
                state <= S_CLAIM;
              end
              ptt_pkg::ACT_SET_TIME: begin
                tick_count <= in_ch.time_value;
                state      <= S_OUT;
              end
              default: begin
                state <= S_OUT;
              end
            endcase
          end
        end
        S_TICK: begin
          // Issue one read per cycle; finish the slot read in the previous cycle.
          if (walk != LAST_CNT) begin
            walk     <= walk + 1'b1;
            pend_v   <= 1'b1;
            pend_idx <= walk_idx;
          end else begin
            pend_v <= 1'b0;
          end
          if (pend_v && slot_in_use[pend_idx] && cd_expire) begin
            slot_ready[pend_idx] <= 1'b1;
          end
          if (walk == LAST_CNT && !pend_v) begin
            state <= S_OUT;
          end
        end
        S_CLAIM: begin
          if (walk == LAST_CNT) begin
            state <= S_OUT;
          end else if (slot_in_use[walk_idx] && slot_ready[walk_idx]) begin
            slot_ready[walk_idx] <= 1'b0;
            if (slot_oneshot[walk_idx]) begin
              slot_in_use[walk_idx] <= 1'b0;
            end
            res_claimed <= ptt_pkg::SLOT_FLD_W'(walk_idx);
            res_found   <= 1'b1;
            state       <= S_OUT;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        S_OUT: begin
          // Hold until the result register is free.
          if (out_free) begin
            out_ch.valid        <= 1'b1;
            out_ch.ready_mask   <= mask_pad[ptt_pkg::MASK_W-1:0];
            out_ch.time_now     <= tick_count;
            out_ch.claimed_slot <= res_claimed;
            out_ch.claim_found  <= res_found;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
